// File: sv/ske_pkg.sv
// shared types, codes and fixed-point helpers for the 2d sph kernel evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package ske_pkg;

	// operation codes carried in the func field
	typedef enum logic [2:0] {
		FN_STD_VAL  = 3'd0,
		FN_STD_D1   = 3'd1,
		FN_STD_D2   = 3'd2,
		FN_STD_GRAD = 3'd3,
		FN_SPK_VAL  = 3'd4,
		FN_SPK_D1   = 3'd5,
		FN_SPK_D2   = 3'd6,
		FN_SPK_GRAD = 3'd7
	} ske_func_t;

	// configuration register indexes
	typedef enum logic {
		REG_RADIUS     = 1'b0,
		REG_INV_RADIUS = 1'b1
	} ske_reg_t;

	localparam logic [31:0] RADIUS_RESET     = 32'd65536;
	localparam logic [31:0] INV_RADIUS_RESET = 32'd65536;
	localparam logic [63:0] INV_PI_Q32       = 64'd1367130551;
	localparam logic [31:0] POS_MAX          = 32'h7fff_ffff;
	localparam logic [31:0] NEG_MAX          = 32'h8000_0000;

	// request and response payloads
	typedef struct packed {
		logic [2:0]         func;
		logic [31:0]        distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} ske_req_t;

	typedef struct packed {
		logic signed [31:0] scalar_result;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
	} ske_rsp_t;

	// item data entering the square root section
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] distance;
		logic [31:0] abs_x;
		logic [31:0] abs_y;
		logic        neg_x;
		logic        neg_y;
	} ske_side_t;

	// item data travelling from the kernel section to the divider
	typedef struct packed {
		logic        grad;
		logic        neg_x;
		logic        neg_y;
		logic        len_zero;
		logic [31:0] len;
		logic [31:0] abs_x;
		logic [31:0] abs_y;
		logic [31:0] scalar_result;
	} ske_carry_t;

	// per-stage control inside the kernel section
	typedef struct packed {
		logic [2:0] eop;
		logic       zero;
		logic       neg;
	} ske_kctl_t;

	// product of two q values rounded half up and capped at 32 bits
	function automatic logic [31:0] mq_round(input logic [63:0] p, input int unsigned frac);
		logic [64:0] s;
		s = ({1'b0, p} + (65'd1 << (frac - 1))) >> frac;
		return (|s[64:32]) ? 32'hffff_ffff : s[31:0];
	endfunction

	// k over pi in q format, from 1/pi in q0.32
	function automatic logic [31:0] k_over_pi(input int unsigned k, input int unsigned frac);
		logic [63:0] s;
		s = (64'(k) * INV_PI_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
		return s[31:0];
	endfunction

	// signed 32-bit saturation of a magnitude and sign
	function automatic logic [31:0] encode_mag(input logic [31:0] mag, input logic neg);
		logic [31:0] m;
		if (neg) begin
			m = (mag > NEG_MAX) ? NEG_MAX : mag;
			return (~m) + 32'd1;
		end
		return (mag > POS_MAX) ? POS_MAX : mag;
	endfunction

endpackage

`default_nettype wire

// File: sv/ske_sqrt.sv
// pipelined squared length and integer square root of the offset point
// depends on ske_pkg for the item data type
`default_nettype none

module ske_sqrt import ske_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire ske_side_t   in_side,
	output logic             out_valid,
	output ske_side_t        out_side,
	output logic [31:0]      len
);

	localparam int unsigned NSTEPS = 32;

	logic [NSTEPS:0]  v_s;
	logic             v_sq_s1;
	logic [63:0]      sqx_s1;
	logic [63:0]      sqy_s1;
	ske_side_t        side_sq_s1;
	logic [63:0]      rem_s  [0:NSTEPS];
	logic [63:0]      res_s  [0:NSTEPS];
	ske_side_t        side_s [0:NSTEPS];

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq_s1 <= 1'b0;
			v_s     <= '0;
		end else if (en) begin
			v_sq_s1 <= in_valid;
			v_s     <= {v_s[NSTEPS-1:0], v_sq_s1};
		end
	end

	// squares, then their sum
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1     <= {32'b0, in_side.abs_x} * {32'b0, in_side.abs_x};
			sqy_s1     <= {32'b0, in_side.abs_y} * {32'b0, in_side.abs_y};
			side_sq_s1 <= in_side;
			rem_s[0]   <= sqx_s1 + sqy_s1;
			res_s[0]   <= '0;
			side_s[0]  <= side_sq_s1;
		end
	end

	// one result bit per stage, restoring method
	for (genvar i = 1; i <= NSTEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (64 - 2 * i);
		logic [63:0] trial;
		assign trial = res_s[i-1] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[i-1] >= trial) begin
					rem_s[i] <= rem_s[i-1] - trial;
					res_s[i] <= (res_s[i-1] >> 1) + BIT;
				end else begin
					rem_s[i] <= rem_s[i-1];
					res_s[i] <= res_s[i-1] >> 1;
				end
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = v_s[NSTEPS];
	assign out_side  = side_s[NSTEPS];
	assign len       = res_s[NSTEPS][31:0];

endmodule

`default_nettype wire

// File: sv/ske_core.sv
// kernel value and derivative chain: q, x, then six rounded multiplies
// depends on ske_pkg for codes, carry types and rounding helpers
`default_nettype none

module ske_core import ske_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire ske_side_t   in_side,
	input  wire logic [31:0] len,
	input  wire logic [31:0] radius,
	input  wire logic [31:0] inv_radius,
	output logic             out_valid,
	output ske_carry_t       out_carry,
	output logic [30:0]      out_gmag
);

	localparam int unsigned NSTG  = 9;
	localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
	localparam logic [64:0] HALF  = 65'd1 << (FRAC_BITS - 1);
	localparam logic [31:0] K4    = k_over_pi(4, FRAC_BITS);
	localparam logic [31:0] K10   = k_over_pi(10, FRAC_BITS);
	localparam logic [31:0] K24   = k_over_pi(24, FRAC_BITS);
	localparam logic [31:0] K30   = k_over_pi(30, FRAC_BITS);
	localparam logic [31:0] K60   = k_over_pi(60, FRAC_BITS);

	logic [NSTG:1] v_s;
	ske_kctl_t     ctl_s [1:NSTG-1];
	ske_carry_t    car_s [1:NSTG];
	logic [63:0]   prod_s1, prod_s2, prod_s3, prod_s4, prod_s5, prod_s6, prod_s7, prod_s8;
	logic [31:0]   q_s2;
	logic [31:0]   b2_s3;
	logic [30:0]   gmag_s9;

	logic          grad_c;
	logic [2:0]    eop_c;
	logic [31:0]   dist_c;
	logic [64:0]   qr_c2;
	logic [31:0]   q_c2;
	logic [31:0]   q2_c3, x_c3, t5_c3, m5_c3, b1_c3, b2_c3;
	logic          neg_c3;
	ske_kctl_t     ctl3_c;
	logic [31:0]   b3_c5, b4_c6;
	logic [31:0]   mag_c9;
	logic [31:0]   scal_c9;
	logic [30:0]   gmag_c9;
	ske_carry_t    car9_c;

	// gradients reuse the first derivative at the point's length
	assign grad_c = (in_side.func[1:0] == 2'b11);
	assign dist_c = grad_c ? len : in_side.distance;
	always_comb begin
		case (in_side.func)
			FN_STD_GRAD: eop_c = FN_STD_D1;
			FN_SPK_GRAD: eop_c = FN_SPK_D1;
			default:     eop_c = in_side.func;
		endcase
	end

	// q rounded and clamped to one
	always_comb begin
		qr_c2 = ({1'b0, prod_s1} + HALF) >> FRAC_BITS;
		q_c2  = (qr_c2 > {33'b0, ONE_Q}) ? ONE_Q : qr_c2[31:0];
	end

	// x, the 5q^2-1 term, sign and the first two operands
	always_comb begin
		q2_c3 = mq_round(prod_s2, FRAC_BITS);
		x_c3  = ctl_s[2].eop[2] ? (ONE_Q - q_s2) : (ONE_Q - q2_c3);
		t5_c3 = (q2_c3 << 2) + q2_c3;
		m5_c3 = (t5_c3 >= ONE_Q) ? (t5_c3 - ONE_Q) : (ONE_Q - t5_c3);
		case (ctl_s[2].eop)
			FN_STD_D1, FN_SPK_D1: neg_c3 = 1'b1;
			FN_STD_D2:            neg_c3 = (t5_c3 < ONE_Q);
			default:              neg_c3 = 1'b0;
		endcase
		case (ctl_s[2].eop)
			FN_STD_D2: b1_c3 = m5_c3;
			FN_SPK_D2: b1_c3 = K60;
			default:   b1_c3 = x_c3;
		endcase
		case (ctl_s[2].eop)
			FN_STD_VAL, FN_SPK_VAL: b2_c3 = x_c3;
			FN_STD_D1:              b2_c3 = q_s2;
			FN_STD_D2:              b2_c3 = K24;
			FN_SPK_D1:              b2_c3 = K30;
			default:                b2_c3 = ONE_Q;
		endcase
		ctl3_c     = ctl_s[2];
		ctl3_c.neg = neg_c3;
	end

	// third and fourth operands depend only on the operation and inv_radius
	always_comb begin
		case (ctl_s[4].eop)
			FN_STD_VAL: b3_c5 = K4;
			FN_SPK_VAL: b3_c5 = K10;
			FN_STD_D1:  b3_c5 = K24;
			FN_SPK_D1:  b3_c5 = ONE_Q;
			default:    b3_c5 = inv_radius;
		endcase
		case (ctl_s[5].eop)
			FN_STD_VAL, FN_SPK_VAL: b4_c6 = ONE_Q;
			default:                b4_c6 = inv_radius;
		endcase
	end

	// final magnitude into scalar result or gradient magnitude
	always_comb begin
		mag_c9 = mq_round(prod_s8, FRAC_BITS);
		if (ctl_s[8].zero || car_s[8].grad)
			scal_c9 = '0;
		else
			scal_c9 = encode_mag(mag_c9, ctl_s[8].neg);
		if (car_s[8].grad && !ctl_s[8].zero)
			gmag_c9 = (mag_c9 > POS_MAX) ? POS_MAX[30:0] : mag_c9[30:0];
		else
			gmag_c9 = '0;
		car9_c               = car_s[8];
		car9_c.scalar_result = scal_c9;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[NSTG-1:1], in_valid};
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[1] <= '{eop: eop_c, zero: (dist_c >= radius), neg: 1'b0};
			car_s[1] <= '{grad: grad_c, neg_x: in_side.neg_x, neg_y: in_side.neg_y,
				len_zero: (len == 32'd0), len: len, abs_x: in_side.abs_x,
				abs_y: in_side.abs_y, scalar_result: 32'd0};
			ctl_s[2] <= ctl_s[1];
			ctl_s[3] <= ctl3_c;
			for (int i = 4; i < NSTG; i++)
				ctl_s[i] <= ctl_s[i-1];
			for (int i = 2; i < NSTG; i++)
				car_s[i] <= car_s[i-1];
			car_s[NSTG] <= car9_c;
			prod_s1 <= {32'b0, dist_c} * {32'b0, inv_radius};
			q_s2    <= q_c2;
			prod_s2 <= {32'b0, q_c2} * {32'b0, q_c2};
			b2_s3   <= b2_c3;
			prod_s3 <= {32'b0, x_c3} * {32'b0, b1_c3};
			prod_s4 <= {32'b0, mq_round(prod_s3, FRAC_BITS)} * {32'b0, b2_s3};
			prod_s5 <= {32'b0, mq_round(prod_s4, FRAC_BITS)} * {32'b0, b3_c5};
			prod_s6 <= {32'b0, mq_round(prod_s5, FRAC_BITS)} * {32'b0, b4_c6};
			prod_s7 <= {32'b0, mq_round(prod_s6, FRAC_BITS)} * {32'b0, inv_radius};
			prod_s8 <= {32'b0, mq_round(prod_s7, FRAC_BITS)} * {32'b0, inv_radius};
			gmag_s9 <= gmag_c9;
		end
	end

	assign out_valid = v_s[NSTG];
	assign out_carry = car_s[NSTG];
	assign out_gmag  = gmag_s9;

endmodule

`default_nettype wire

// File: sv/ske_div.sv
// gradient components: magnitude times |p|, rounded division by length, sign
// depends on ske_pkg for carry and response types
`default_nettype none

module ske_div import ske_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire ske_carry_t  in_carry,
	input  wire logic [30:0] in_gmag,
	output logic             out_valid,
	output ske_rsp_t         out_rsp
);

	localparam int unsigned NQ = 31;

	logic [NQ+2:0] v_s;
	logic [63:0]   px_s1, py_s1;
	ske_carry_t    car_s1;
	logic [63:0]   remx_s [0:NQ];
	logic [63:0]   remy_s [0:NQ];
	logic [30:0]   qx_s   [0:NQ];
	logic [30:0]   qy_s   [0:NQ];
	ske_carry_t    car_s  [0:NQ];
	ske_rsp_t      rsp_s;
	logic          gok_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[NQ+1:0], in_valid};
	end

	// products, then the rounding offset of half the length
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1     <= {33'b0, in_gmag} * {32'b0, in_carry.abs_x};
			py_s1     <= {33'b0, in_gmag} * {32'b0, in_carry.abs_y};
			car_s1    <= in_carry;
			remx_s[0] <= px_s1 + {33'b0, car_s1.len[31:1]};
			remy_s[0] <= py_s1 + {33'b0, car_s1.len[31:1]};
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			car_s[0]  <= car_s1;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 1; i <= NQ; i++) begin : g_step
		logic [63:0] dv;
		assign dv = {32'b0, car_s[i-1].len} << (NQ - i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (remx_s[i-1] >= dv) begin
					remx_s[i] <= remx_s[i-1] - dv;
					qx_s[i]   <= {qx_s[i-1][29:0], 1'b1};
				end else begin
					remx_s[i] <= remx_s[i-1];
					qx_s[i]   <= {qx_s[i-1][29:0], 1'b0};
				end
				if (remy_s[i-1] >= dv) begin
					remy_s[i] <= remy_s[i-1] - dv;
					qy_s[i]   <= {qy_s[i-1][29:0], 1'b1};
				end else begin
					remy_s[i] <= remy_s[i-1];
					qy_s[i]   <= {qy_s[i-1][29:0], 1'b0};
				end
				car_s[i] <= car_s[i-1];
			end
		end
	end

	// sign and zero-length handling
	assign gok_c = car_s[NQ].grad && !car_s[NQ].len_zero;
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s.scalar_result <= car_s[NQ].scalar_result;
			rsp_s.grad_x <= gok_c ? encode_mag({1'b0, qx_s[NQ]}, car_s[NQ].neg_x) : 32'd0;
			rsp_s.grad_y <= gok_c ? encode_mag({1'b0, qy_s[NQ]}, car_s[NQ].neg_y) : 32'd0;
		end
	end

	assign out_valid = v_s[NQ+2];
	assign out_rsp   = rsp_s;

endmodule

`default_nettype wire

// File: sv/sph_kernel_2d_evaluator.sv
// 2d sph kernel evaluator (standard and spiky), q16.16 fixed point
// throughput: one request per cycle; the pipeline freezes only while the skid register is full
// every stage moves on one enable; the skid register lets requests flow while a response waits
// reset: clears all valid bits and loads radius and inv_radius with 1.0; no clearing pass
// depends on ske_pkg, ske_sqrt, ske_core, ske_div
`default_nettype none

module sph_kernel_2d_evaluator import ske_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire ske_req_t    req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output ske_rsp_t         rsp,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic        en;
	logic [31:0] radius_q, inv_radius_q;
	logic        v_s1;
	ske_side_t   side_s1;
	logic        sq_valid, core_valid, div_valid;
	ske_side_t   sq_side;
	logic [31:0] sq_len;
	ske_carry_t  core_carry;
	logic [30:0] core_gmag;
	ske_rsp_t    div_rsp;
	logic        rsp_valid_q, skid_valid_q;
	ske_rsp_t    rsp_q, skid_q;
	logic        take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RESET;
			inv_radius_q <= INV_RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:     radius_q     <= cfg_data;
				REG_INV_RADIUS: inv_radius_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign en        = !skid_valid_q;
	assign req_stall = skid_valid_q;

	// input stage: point magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.func     <= req.func;
			side_s1.distance <= req.distance;
			side_s1.neg_x    <= req.point_x[31];
			side_s1.neg_y    <= req.point_y[31];
			side_s1.abs_x    <= req.point_x[31] ? (~req.point_x) + 32'd1 : req.point_x;
			side_s1.abs_y    <= req.point_y[31] ? (~req.point_y) + 32'd1 : req.point_y;
		end
	end

	ske_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_side   (side_s1),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.len       (sq_len)
	);

	ske_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sq_valid),
		.in_side    (sq_side),
		.len        (sq_len),
		.radius     (radius_q),
		.inv_radius (inv_radius_q),
		.out_valid  (core_valid),
		.out_carry  (core_carry),
		.out_gmag   (core_gmag)
	);

	ske_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (core_valid),
		.in_carry  (core_carry),
		.in_gmag   (core_gmag),
		.out_valid (div_valid),
		.out_rsp   (div_rsp)
	);

	// output register with skid entry
	assign take = rsp_valid_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || take) begin
			rsp_valid_q <= div_valid;
		end else if (div_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				rsp_q <= skid_q;
		end else if (!rsp_valid_q || take) begin
			rsp_q <= div_rsp;
		end else if (div_valid) begin
			skid_q <= div_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: sv/ske_checker.sv
// port-level checks for the sph kernel evaluator, bound to the top level
// depends on ske_pkg for the response type
`default_nettype none

module ske_checker import ske_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_stall,
	input wire logic     rsp_valid,
	input wire logic     rsp_stall,
	input wire ske_rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a response is either scalar or gradient, never both
	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.scalar_result == 32'sd0) || (rsp.grad_x == 32'sd0 && rsp.grad_y == 32'sd0))
		else $error("scalar and gradient both nonzero");

	// requests are held back only after a stalled response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> $past(rsp_valid && rsp_stall))
		else $error("request stalled without a waiting response");

	// a response transfer frees the input side
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall |=> !req_stall)
		else $error("request still stalled after a response transfer");

endmodule

bind sph_kernel_2d_evaluator ske_checker u_ske_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// File: verif/tb_sph_kernel_2d_evaluator.sv
// testbench for sph_kernel_2d_evaluator: directed corners, register sweeps, random traffic
// depends on ske_pkg and the evaluator rtl; results checked against an in-bench kernel predictor
`timescale 1ns / 100ps

module tb_sph_kernel_2d_evaluator;
	import ske_pkg::*;

	localparam int unsigned FRAC    = 16;
	localparam logic [63:0] ONE_Q   = 64'd1 << FRAC;
	localparam logic [63:0] HALF_Q  = 64'd1 << (FRAC - 1);
	localparam logic [63:0] CAP32   = 64'hffff_ffff;
	localparam int          DRAIN   = 120;
	localparam int          WDOG    = 20000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	ske_req_t    req;
	logic        rsp_valid;
	logic        rsp_stall;
	ske_rsp_t    rsp;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the registers
	logic [63:0] mdl_radius;
	logic [63:0] mdl_inv_radius;

	ske_rsp_t    kernel_results_q[$];
	int          err_count;
	int          idle_cycles;
	bit          quiet;

	sph_kernel_2d_evaluator #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// fixed-point helpers of the predictor
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = (a * b + HALF_Q) >> FRAC;
		return (r > CAP32) ? CAP32 : r;
	endfunction

	function automatic logic [63:0] kpi(input logic [63:0] k);
		return (k * INV_PI_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
	endfunction

	function automatic logic [63:0] scale_ir(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			v = qmul(v, mdl_inv_radius);
		return v;
	endfunction

	function automatic logic [31:0] sat_encode(input logic [63:0] mag, input bit neg);
		if (neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			return 32'((64'h1_0000_0000 - mag) & CAP32);
		end
		return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// magnitude and sign of a scalar kernel quantity at distance d
	function automatic logic [63:0] kernel_mag(input ske_func_t fn, input logic [63:0] d,
			output bit neg);
		logic [63:0] q, x, q2, t, m;
		neg = 0;
		if (d >= mdl_radius)
			return 0;
		q = (d * mdl_inv_radius + HALF_Q) >> FRAC;
		if (q > ONE_Q)
			q = ONE_Q;
		case (fn)
			FN_STD_VAL: begin
				x = ONE_Q - qmul(q, q);
				return scale_ir(qmul(kpi(4), qmul(qmul(x, x), x)), 2);
			end
			FN_STD_D1: begin
				x = ONE_Q - qmul(q, q);
				neg = 1;
				return scale_ir(qmul(kpi(24), qmul(q, qmul(x, x))), 3);
			end
			FN_STD_D2: begin
				q2 = qmul(q, q);
				x = ONE_Q - q2;
				t = 5 * q2;
				if (t >= ONE_Q) begin
					m = t - ONE_Q;
				end else begin
					m = ONE_Q - t;
					neg = 1;
				end
				m = scale_ir(qmul(kpi(24), qmul(x, m)), 4);
				if (m == 0)
					neg = 0;
				return m;
			end
			FN_SPK_VAL: begin
				x = ONE_Q - q;
				return scale_ir(qmul(kpi(10), qmul(qmul(x, x), x)), 2);
			end
			FN_SPK_D1: begin
				x = ONE_Q - q;
				neg = 1;
				return scale_ir(qmul(kpi(30), qmul(x, x)), 3);
			end
			default: begin
				x = ONE_Q - q;
				return scale_ir(qmul(kpi(60), x), 4);
			end
		endcase
	endfunction

	function automatic ske_rsp_t predict_kernel(input ske_req_t r);
		ske_rsp_t    o;
		ske_func_t   fn;
		bit          neg, nx, ny;
		logic [63:0] ax, ay, len, m;
		o = '0;
		fn = ske_func_t'(r.func);
		if (fn != FN_STD_GRAD && fn != FN_SPK_GRAD) begin
			m = kernel_mag(fn, {32'd0, r.distance}, neg);
			o.scalar_result = sat_encode(m, neg);
		end else begin
			nx = r.point_x[31];
			ny = r.point_y[31];
			ax = nx ? 64'h1_0000_0000 - {32'd0, r.point_x} : {32'd0, r.point_x};
			ay = ny ? 64'h1_0000_0000 - {32'd0, r.point_y} : {32'd0, r.point_y};
			len = int_sqrt(ax * ax + ay * ay);
			if (len != 0) begin
				m = kernel_mag(fn == FN_STD_GRAD ? FN_STD_D1 : FN_SPK_D1, len, neg);
				if (m > 64'h7fff_ffff)
					m = 64'h7fff_ffff;
				o.grad_x = sat_encode((m * ax + len / 2) / len, nx);
				o.grad_y = sat_encode((m * ay + len / 2) / len, ny);
			end
		end
		return o;
	endfunction

	// request transfers queue their expectation, response transfers are checked
	always @(posedge clk) begin
		ske_rsp_t exp_rsp;
		if (arst_n) begin
			if (req_valid && !req_stall)
				kernel_results_q.push_back(predict_kernel(req));
			if (rsp_valid && !rsp_stall) begin
				if (kernel_results_q.size() == 0) begin
					$error("unexpected response transfer");
					err_count++;
				end else begin
					exp_rsp = kernel_results_q.pop_front();
					if (rsp.scalar_result !== exp_rsp.scalar_result) begin
						$error("scalar_result exp %h got %h", exp_rsp.scalar_result,
							rsp.scalar_result);
						err_count++;
					end
					if (rsp.grad_x !== exp_rsp.grad_x) begin
						$error("grad_x exp %h got %h", exp_rsp.grad_x, rsp.grad_x);
						err_count++;
					end
					if (rsp.grad_y !== exp_rsp.grad_y) begin
						$error("grad_y exp %h got %h", exp_rsp.grad_y, rsp.grad_y);
						err_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG) begin
			$display("** sph_kernel_2d_evaluator: FAILED **");
			$finish;
		end
	end

	// receiver stalls in random bursts
	always @(negedge clk) begin
		int burst;
		if (quiet || !arst_n) begin
			rsp_stall <= 1'b0;
		end else if (burst > 0) begin
			burst--;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			burst = $urandom_range(0, 8);
		end else begin
			rsp_stall <= 1'b0;
			burst = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
		end
	end

	// one request transfer, possibly followed by a sender gap
	task automatic send_item(input ske_req_t r);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (kernel_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input ske_reg_t idx, input logic [31:0] val);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIUS)
			mdl_radius = {32'd0, val};
		else
			mdl_inv_radius = {32'd0, val};
	endtask

	task automatic set_radius(input logic [31:0] r, input logic [31:0] ir);
		write_reg(REG_RADIUS, r);
		write_reg(REG_INV_RADIUS, ir);
	endtask

	function automatic ske_req_t make_req(input ske_func_t fn, input logic [31:0] d,
			input logic [31:0] px, input logic [31:0] py);
		ske_req_t r;
		r.func = fn;
		r.distance = d;
		r.point_x = px;
		r.point_y = py;
		return r;
	endfunction

	// random item shaped around the current radius
	function automatic ske_req_t rand_req();
		logic [63:0] lim;
		logic [31:0] d, px, py;
		lim = mdl_radius + mdl_radius / 4 + 1;
		if (lim > 64'h7fff_ffff)
			lim = 64'h7fff_ffff;
		if ($urandom_range(0, 9) == 0) begin
			d = $urandom;
			px = $urandom;
			py = $urandom;
		end else begin
			d = 32'($urandom % lim);
			px = 32'($urandom % lim);
			py = 32'($urandom % lim);
			if ($urandom_range(0, 1))
				px = -px;
			if ($urandom_range(0, 1))
				py = -py;
			if ($urandom_range(0, 15) == 0)
				d = mdl_radius[31:0] - 32'($urandom_range(0, 1));
		end
		return make_req(ske_func_t'($urandom_range(0, 7)), d, px, py);
	endfunction

	// every operation at the field extremes with reset registers
	task automatic test_directed();
		for (int f = 0; f < 8; f++) begin
			send_item(make_req(ske_func_t'(f), 32'd0, 32'd0, 32'd0));
			send_item(make_req(ske_func_t'(f), 32'h0000_7fff, 32'h8000_0000, 32'h7fff_ffff));
			send_item(make_req(ske_func_t'(f), 32'hffff_ffff, 32'h0000_4000, 32'hffff_c000));
		end
		send_item(make_req(FN_STD_D2, 32'h0000_ffff, 32'h0000_ffff, 32'h0001_0000));
	endtask

	// register extremes, inconsistent pairs and typical radii
	task automatic test_config_sweep();
		logic [31:0] rad[6] = '{32'h0002_0000, 32'hffff_ffff, 32'd1, 32'h0000_8000,
			32'h0064_0000, 32'h0003_0000};
		logic [31:0] inv[6] = '{32'h0000_8000, 32'd1, 32'hffff_ffff, 32'h0002_0000,
			32'd655, 32'h0004_0000};
		for (int s = 0; s < 6; s++) begin
			set_radius(rad[s], inv[s]);
			for (int f = 0; f < 8; f++) begin
				send_item(make_req(ske_func_t'(f), rad[s] - 1, rad[s] >> 1, -(rad[s] >> 2)));
				send_item(make_req(ske_func_t'(f), rad[s] >> 2, 32'd0, 32'd1));
			end
			repeat (60) send_item(rand_req());
		end
	endtask

	task automatic test_random();
		logic [31:0] r;
		logic [63:0] ir;
		for (int s = 0; s < 12; s++) begin
			r = (s % 3 == 0) ? 32'($urandom) : 32'($urandom_range(32'h0000_1000, 32'h0040_0000));
			if (r == 0)
				r = 1;
			ir = (64'd1 << 32) / r;
			if (ir > CAP32)
				ir = CAP32;
			if (ir == 0)
				ir = 1;
			set_radius(r, ir[31:0]);
			if (s == 6)
				drain_results();
			if (s == 11)
				quiet = 1;
			repeat (114) send_item(rand_req());
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		cfg_we = 0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		err_count = 0;
		idle_cycles = 0;
		quiet = 0;
		mdl_radius = {32'd0, RADIUS_RESET};
		mdl_inv_radius = {32'd0, INV_RADIUS_RESET};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_config_sweep();
		test_random();
		drain_results();
		if (err_count == 0)
			$display("** sph_kernel_2d_evaluator: PASSED **");
		else
			$display("** sph_kernel_2d_evaluator: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
sv/ske_pkg.sv
sv/ske_sqrt.sv
sv/ske_core.sv
sv/ske_div.sv
sv/sph_kernel_2d_evaluator.sv
sv/ske_checker.sv
verif/tb_sph_kernel_2d_evaluator.sv
